@@ design/assert_macros.svh @@
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define CKB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal must hold its value over a cycle in which the word is stalled
`define CKB_ASSERT_HOLD(lbl, clk, rst_n, stall, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (stall) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ design/ckb_pkg.sv @@
package ckb_pkg;

	// fixed field widths
	localparam int COORD_W = 11;
	localparam int PIX_W   = 16;
	localparam int DATA_W  = 16;
	localparam int IDX_W   = 3;

	// register map
	typedef enum logic [IDX_W-1:0] {
		REG_OFFSET_X      = 3'd0,
		REG_OFFSET_Y      = 3'd1,
		REG_SPAN_X        = 3'd2,
		REG_SPAN_Y        = 3'd3,
		REG_SPRITE_HEIGHT = 3'd4,
		REG_FRAME_HEIGHT  = 3'd5,
		REG_KEY           = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] offset_x;
		logic signed [COORD_W-1:0] offset_y;
		logic [COORD_W-1:0]        span_x;
		logic [COORD_W-1:0]        span_y;
		logic [COORD_W-1:0]        sprite_height;
		logic [COORD_W-1:0]        frame_height;
		logic [PIX_W-1:0]          transparent_key;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		offset_x:        '0,
		offset_y:        '0,
		span_x:          '0,
		span_y:          '0,
		sprite_height:   COORD_W'(1),
		frame_height:    COORD_W'(1),
		transparent_key: '0
	};

	// stage load enables from the top-level flow control
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_out;
	} pipe_ctl_t;

endpackage

@@ design/color_key_sprite_blit.sv @@
// Colour-keyed sprite blit: sprite pixel words in, framebuffer write words out.
// Pipeline: window test, multiply and add, each registered, in that order after input accept.
// Throughput: one word per cycle; the input is taken whenever the pipeline can move.
// Reset: asynchronous, clears the pipeline, the column and row counters and
// puts every configuration register at its reset value.
module color_key_sprite_blit #(
	parameter int FRAME_PIXELS = 32768,
	parameter int MAX_DIM      = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [ckb_pkg::IDX_W-1:0]             cfg_index,
	input  logic [ckb_pkg::DATA_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ckb_pkg::PIX_W-1:0]             pixel,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  write_enable,
	output logic [$clog2(FRAME_PIXELS)-1:0]       fb_address,
	output logic [ckb_pkg::PIX_W-1:0]             fb_pixel,
	output logic                                  done_res
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = ((CW > ckb_pkg::COORD_W) ? CW : ckb_pkg::COORD_W) + 1;
	localparam int AW = $clog2(FRAME_PIXELS);

	ckb_pkg::cfg_t      cfg;
	ckb_pkg::pipe_ctl_t ctl;
	logic               v_s1_q;
	logic               v_s2_q;
	logic               v_out_q;
	logic               adv_out;
	logic               adv_s2;
	logic               accept;
	logic [CW-1:0]      col;
	logic [CW-1:0]      row;
	logic               hit_s1;
	logic [DW-1:0]      fx_s1;
	logic [DW-1:0]      fy_s1;
	logic [ckb_pkg::PIX_W-1:0] pixel_s1;
	logic               last_s1;

	// flow control: a stage loads when it is empty or its contents move on
	always_comb begin
		adv_out      = !v_out_q || out_ready;
		adv_s2       = !v_s2_q || adv_out;
		in_ready     = !v_s1_q || adv_s2;
		accept       = in_valid && in_ready;
		ctl.load_s1  = in_ready;
		ctl.load_s2  = adv_s2;
		ctl.load_out = adv_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1_q <= in_valid;
			end
			if (adv_s2) begin
				v_s2_q <= v_s1_q;
			end
			if (adv_out) begin
				v_out_q <= v_s2_q;
			end
		end
	end

	assign out_valid = v_out_q;

	ckb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ckb_pos_cnt #(
		.MAX_DIM (MAX_DIM),
		.CW      (CW)
	) u_pos_cnt (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.last          (last),
		.sprite_height (cfg.sprite_height),
		.col           (col),
		.row           (row)
	);

	ckb_clip #(
		.CW (CW),
		.DW (DW)
	) u_clip (
		.clk             (clk),
		.ctl             (ctl),
		.offset_x        (cfg.offset_x),
		.offset_y        (cfg.offset_y),
		.span_x          (cfg.span_x),
		.span_y          (cfg.span_y),
		.transparent_key (cfg.transparent_key),
		.col             (col),
		.row             (row),
		.pixel           (pixel),
		.last            (last),
		.hit_s1          (hit_s1),
		.fx_s1           (fx_s1),
		.fy_s1           (fy_s1),
		.pixel_s1        (pixel_s1),
		.last_s1         (last_s1)
	);

	ckb_addr #(
		.FRAME_PIXELS (FRAME_PIXELS),
		.DW           (DW),
		.AW           (AW)
	) u_addr (
		.clk          (clk),
		.ctl          (ctl),
		.frame_height (cfg.frame_height),
		.hit_s1       (hit_s1),
		.fx_s1        (fx_s1),
		.fy_s1        (fy_s1),
		.pixel_s1     (pixel_s1),
		.last_s1      (last_s1),
		.write_enable (write_enable),
		.fb_address   (fb_address),
		.fb_pixel     (fb_pixel),
		.done_res     (done_res)
	);

endmodule

@@ design/ckb_regs.sv @@
module ckb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [ckb_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ckb_pkg::DATA_W-1:0] cfg_data,
	output ckb_pkg::cfg_t              cfg
);

	ckb_pkg::cfg_t cfg_q;

	// register file, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ckb_pkg::CFG_RESET;
		end else if (cfg_write) begin
			case (ckb_pkg::reg_idx_t'(cfg_index))
				ckb_pkg::REG_OFFSET_X: begin
					cfg_q.offset_x <= $signed(cfg_data[ckb_pkg::COORD_W-1:0]);
				end
				ckb_pkg::REG_OFFSET_Y: begin
					cfg_q.offset_y <= $signed(cfg_data[ckb_pkg::COORD_W-1:0]);
				end
				ckb_pkg::REG_SPAN_X: begin
					cfg_q.span_x <= cfg_data[ckb_pkg::COORD_W-1:0];
				end
				ckb_pkg::REG_SPAN_Y: begin
					cfg_q.span_y <= cfg_data[ckb_pkg::COORD_W-1:0];
				end
				ckb_pkg::REG_SPRITE_HEIGHT: begin
					cfg_q.sprite_height <= cfg_data[ckb_pkg::COORD_W-1:0];
				end
				ckb_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data[ckb_pkg::COORD_W-1:0];
				end
				ckb_pkg::REG_KEY: begin
					cfg_q.transparent_key <= cfg_data[ckb_pkg::PIX_W-1:0];
				end
				default: begin
					// unmapped index: write ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/ckb_pos_cnt.sv @@
module ckb_pos_cnt #(
	parameter int MAX_DIM = 1024,
	parameter int CW      = $clog2(MAX_DIM)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        last,
	input  logic [ckb_pkg::COORD_W-1:0] sprite_height,
	output logic [CW-1:0]               col,
	output logic [CW-1:0]               row
);

	localparam int HW = (CW + 1 > ckb_pkg::COORD_W) ? CW + 1 : ckb_pkg::COORD_W;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW:0]   row_inc;
	logic [CW:0]   col_inc;
	logic          row_wrap;

	// next row wraps at the sprite height or the dimension limit
	always_comb begin
		row_inc  = (CW + 1)'(row_q) + (CW + 1)'(1);
		col_inc  = (CW + 1)'(col_q) + (CW + 1)'(1);
		row_wrap = (HW'(row_inc) >= HW'(sprite_height)) ||
			(row_inc >= (CW + 1)'(MAX_DIM));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_wrap) begin
				row_q <= '0;
				col_q <= (col_inc >= (CW + 1)'(MAX_DIM)) ? '0 : col_inc[CW-1:0];
			end else begin
				row_q <= row_inc[CW-1:0];
			end
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

@@ design/ckb_clip.sv @@
module ckb_clip #(
	parameter int CW = 10,
	parameter int DW = 12
) (
	input  logic                               clk,
	input  ckb_pkg::pipe_ctl_t                 ctl,
	input  logic signed [ckb_pkg::COORD_W-1:0] offset_x,
	input  logic signed [ckb_pkg::COORD_W-1:0] offset_y,
	input  logic [ckb_pkg::COORD_W-1:0]        span_x,
	input  logic [ckb_pkg::COORD_W-1:0]        span_y,
	input  logic [ckb_pkg::PIX_W-1:0]          transparent_key,
	input  logic [CW-1:0]                      col,
	input  logic [CW-1:0]                      row,
	input  logic [ckb_pkg::PIX_W-1:0]          pixel,
	input  logic                               last,
	output logic                               hit_s1,
	output logic [DW-1:0]                      fx_s1,
	output logic [DW-1:0]                      fy_s1,
	output logic [ckb_pkg::PIX_W-1:0]          pixel_s1,
	output logic                               last_s1
);

	localparam int EXT = DW - ckb_pkg::COORD_W;

	logic [ckb_pkg::COORD_W-1:0] skip_x;
	logic [ckb_pkg::COORD_W-1:0] skip_y;
	logic [DW-1:0]               col_x;
	logic [DW-1:0]               row_x;
	logic                        in_x;
	logic                        in_y;
	logic                        hit;
	logic [DW-1:0]               fx;
	logic [DW-1:0]               fy;

	// window test in sprite coordinates, frame coordinates by offset
	always_comb begin
		skip_x = offset_x[ckb_pkg::COORD_W-1] ? (~offset_x + 1'b1) : '0;
		skip_y = offset_y[ckb_pkg::COORD_W-1] ? (~offset_y + 1'b1) : '0;
		col_x  = DW'(col);
		row_x  = DW'(row);
		in_x   = (col_x >= DW'(skip_x)) && ((col_x - DW'(skip_x)) < DW'(span_x));
		in_y   = (row_x >= DW'(skip_y)) && ((row_x - DW'(skip_y)) < DW'(span_y));
		hit    = in_x && in_y && (pixel != transparent_key);
		// non-negative whenever the pixel lies in the window
		fx     = col_x + {{EXT{offset_x[ckb_pkg::COORD_W-1]}}, offset_x};
		fy     = row_x + {{EXT{offset_y[ckb_pkg::COORD_W-1]}}, offset_y};
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			hit_s1   <= hit;
			fx_s1    <= fx;
			fy_s1    <= fy;
			pixel_s1 <= pixel;
			last_s1  <= last;
		end
	end

endmodule

@@ design/ckb_addr.sv @@
module ckb_addr #(
	parameter int FRAME_PIXELS = 32768,
	parameter int DW           = 12,
	parameter int AW           = $clog2(FRAME_PIXELS)
) (
	input  logic                        clk,
	input  ckb_pkg::pipe_ctl_t          ctl,
	input  logic [ckb_pkg::COORD_W-1:0] frame_height,
	input  logic                        hit_s1,
	input  logic [DW-1:0]               fx_s1,
	input  logic [DW-1:0]               fy_s1,
	input  logic [ckb_pkg::PIX_W-1:0]   pixel_s1,
	input  logic                        last_s1,
	output logic                        write_enable,
	output logic [AW-1:0]               fb_address,
	output logic [ckb_pkg::PIX_W-1:0]   fb_pixel,
	output logic                        done_res
);

	localparam int PW = DW + ckb_pkg::COORD_W;
	localparam int SW = PW + 1;

	logic [PW-1:0]               prod_s2;
	logic [DW-1:0]               fy_s2;
	logic                        hit_s2;
	logic [ckb_pkg::PIX_W-1:0]   pixel_s2;
	logic                        last_s2;
	logic [SW-1:0]               sum;
	logic                        wr;

	// column times stride
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_s2  <= PW'(fx_s1) * PW'(frame_height);
			fy_s2    <= fy_s1;
			hit_s2   <= hit_s1;
			pixel_s2 <= pixel_s1;
			last_s2  <= last_s1;
		end
	end

	// add the row, drop writes beyond the frame capacity
	always_comb begin
		sum = SW'(prod_s2) + SW'(fy_s2);
		wr  = hit_s2 && (sum < SW'(FRAME_PIXELS));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			write_enable <= wr;
			fb_address   <= wr ? sum[AW-1:0] : '0;
			fb_pixel     <= pixel_s2;
			done_res     <= last_s2;
		end
	end

endmodule

@@ design/ckb_checker.sv @@
`include "assert_macros.svh"

module ckb_checker #(
	parameter int FRAME_PIXELS = 32768
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            write_enable,
	input logic [$clog2(FRAME_PIXELS)-1:0] fb_address,
	input logic [ckb_pkg::PIX_W-1:0]       fb_pixel,
	input logic                            done_res
);

	// a stalled result word stays put
	`CKB_ASSERT(a_out_hold_valid, clk, arst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
	`CKB_ASSERT_HOLD(a_out_hold_data, clk, arst_n, out_valid && !out_ready, {write_enable, fb_address, fb_pixel, done_res}, "result word changed while stalled")

	// an empty or draining output never blocks the input side
	`CKB_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled with empty output")
	`CKB_ASSERT(a_ready_when_taken, clk, arst_n, out_valid && out_ready |-> in_ready, "input stalled while output drains")

	// no address is shown without a write
	`CKB_ASSERT(a_addr_zero, clk, arst_n, out_valid && !write_enable |-> fb_address == '0, "address set on a skipped pixel")

endmodule

bind color_key_sprite_blit ckb_checker #(
	.FRAME_PIXELS (FRAME_PIXELS)
) u_ckb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.write_enable (write_enable),
	.fb_address   (fb_address),
	.fb_pixel     (fb_pixel),
	.done_res     (done_res)
);
